### hw/rtl/slt_pkg.sv
// shared types, character codes and classifier functions for the source line tokenizer
// no dependencies; imported by every slt module but slt_in_reg
package slt_pkg;

  localparam int unsigned LINE_W = 32;
  localparam int unsigned COL_OUT_W = 12;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_INT    = 2'd1,
    KIND_STRING = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_WORD    = 5'b00010,
    MODE_STRING  = 5'b00100,
    MODE_ESCAPE  = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e                  kind;
    logic [LINE_W-1:0]      line_index;
    logic [COL_OUT_W-1:0]   start_column;
    logic [COL_OUT_W-1:0]   end_column;
    logic                   last;
  } result_t;

  // results of one scanned item, count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### hw/rtl/slt_in_reg.sv
// input register for the tokenizer: holds one accepted item until the scanner takes it
// uses no package items
module slt_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_code
  input  logic       s_axis_tuser,   // end_of_line
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eol_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       eol_q;
  logic       load;

  assign s_axis_tready = !valid_q || take_i;
  assign load = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= s_axis_tdata;
      eol_q  <= s_axis_tuser;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eol_o   = eol_q;

endmodule

### hw/rtl/slt_scanner.sv
// scanner state machine: line and column counters, token mode, result formation
// depends on slt_pkg
module slt_scanner #(
  parameter int unsigned COLUMN_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         char_i,
  input  logic               eol_i,
  output slt_pkg::step_out_t step_o
);
  import slt_pkg::*;

  localparam logic [COLUMN_BITS-1:0] ColMax = {COLUMN_BITS{1'b1}};

  mode_e                   mode_q, mode_d;
  logic [COLUMN_BITS-1:0]  start_q, start_d;
  logic [COLUMN_BITS-1:0]  col_q, col_d;
  logic [LINE_W-1:0]       line_q, line_d;
  logic                    all_dig_q, all_dig_d;
  logic                    dig_seen_q, dig_seen_d;

  logic [COLUMN_BITS-1:0]  col_next;
  logic                    delim;
  logic                    do_begin;
  logic [1:0]              cnt;
  result_t                 res [2];

  // columns leave the block as their low 12 bits
  function automatic logic [COL_OUT_W-1:0] out_col(input logic [COLUMN_BITS-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[COL_OUT_W-1:0];
  endfunction

  function automatic result_t mk(input kind_e k, input logic [LINE_W-1:0] ln,
                                 input logic [COLUMN_BITS-1:0] s,
                                 input logic [COLUMN_BITS-1:0] e);
    result_t r;
    r.kind         = k;
    r.line_index   = ln;
    r.start_column = out_col(s);
    r.end_column   = out_col(e);
    r.last         = 1'b0;
    return r;
  endfunction

  assign col_next = (col_q == ColMax) ? ColMax : col_q + 1'b1;
  assign delim    = is_space(char_i) || (char_i == CH_HASH) || is_bracket(char_i);

  always_comb begin
    mode_d     = mode_q;
    start_d    = start_q;
    col_d      = col_q;
    line_d     = line_q;
    all_dig_d  = all_dig_q;
    dig_seen_d = dig_seen_q;
    cnt        = 2'd0;
    do_begin   = 1'b0;
    res[0]     = mk(KIND_WORD, line_q, start_q, col_q);
    res[1]     = mk(KIND_WORD, line_q, start_q, col_q);

    if (eol_i) begin
      if (mode_q == MODE_WORD) begin
        res[0] = mk((all_dig_q && dig_seen_q) ? KIND_INT : KIND_WORD, line_q, start_q, col_q);
        cnt    = 2'd1;
      end else if ((mode_q == MODE_STRING) || (mode_q == MODE_ESCAPE)) begin
        res[0] = mk(KIND_ERROR, line_q, start_q, col_q);
        cnt    = 2'd1;
      end
      if (line_q != {LINE_W{1'b1}}) begin
        line_d = line_q + 1'b1;
      end
      col_d  = '0;
      mode_d = MODE_IDLE;
    end else begin
      col_d = col_next;
      unique case (mode_q)
        MODE_COMMENT: begin
        end
        MODE_STRING: begin
          if (char_i == CH_BSLASH) begin
            mode_d = MODE_ESCAPE;
          end else if (char_i == CH_QUOTE) begin
            res[0] = mk(KIND_STRING, line_q, start_q, col_next);
            cnt    = 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_ESCAPE: begin
          mode_d = MODE_STRING;
        end
        MODE_WORD: begin
          if (delim) begin
            res[0]   = mk((all_dig_q && dig_seen_q) ? KIND_INT : KIND_WORD,
                          line_q, start_q, col_q);
            cnt      = 2'd1;
            do_begin = 1'b1;
          end else if (is_digit(char_i)) begin
            dig_seen_d = 1'b1;
          end else begin
            all_dig_d = 1'b0;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase

      if (do_begin) begin
        priority if (is_space(char_i)) begin
          mode_d = MODE_IDLE;
        end else if (char_i == CH_HASH) begin
          mode_d = MODE_COMMENT;
        end else if (char_i == CH_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = col_q;
        end else if (is_bracket(char_i)) begin
          mode_d         = MODE_IDLE;
          res[cnt[0]]    = mk(KIND_WORD, line_q, col_q, col_next);
          cnt            = cnt + 2'd1;
        end else begin
          mode_d     = MODE_WORD;
          start_d    = col_q;
          dig_seen_d = is_digit(char_i);
          all_dig_d  = (char_i == CH_MINUS) || is_digit(char_i);
        end
      end
    end

    if (cnt == 2'd2) begin
      res[1].last = 1'b1;
    end else if (cnt == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      start_q    <= '0;
      col_q      <= '0;
      line_q     <= LINE_W'(1);
      all_dig_q  <= 1'b1;
      dig_seen_q <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      start_q    <= start_d;
      col_q      <= col_d;
      line_q     <= line_d;
      all_dig_q  <= all_dig_d;
      dig_seen_q <= dig_seen_d;
    end
  end

  assign step_o.cnt = cnt;
  assign step_o.r0  = res[0];
  assign step_o.r1  = res[1];

endmodule

### hw/rtl/slt_out_fifo.sv
// four-entry result queue: takes up to two results per cycle, hands out one
// depends on slt_pkg
module slt_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slt_pkg::step_out_t step_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output slt_pkg::result_t   data_o
);
  import slt_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] count_q, count_d;
  logic [1:0] n_push;
  logic       pop;

  // room for the worst case of two results
  assign room_o  = count_q <= 3'd2;
  assign valid_o = count_q != 3'd0;
  assign pop     = valid_o && ready_i;
  assign n_push  = push_i ? step_i.cnt : 2'd0;

  always_comb begin
    wr_d    = wr_q + n_push;
    rd_d    = rd_q + {1'b0, pop};
    count_d = count_q + {1'b0, n_push} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= step_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 2'd1] <= step_i.r1;
    end
  end

  assign data_o = mem_q[rd_q];

endmodule

### hw/rtl/source_line_tokenizer.sv
// source line tokenizer: byte stream in, token spans out
// path: an item waits in the input register until the result queue has room; its results
// (two when a bracket closes a word) are registered in the queue before the master side
// throughput: one item per cycle while the queue has room; results leave at one per cycle when taken
// reset: asynchronous active low; line 1, column 0, scanner idle, queue empty
module source_line_tokenizer #(
  parameter int unsigned COLUMN_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [1:0] token_kind, [33:2] line_index,
                                      // [45:34] start_column, [57:46] end_column, zero
  output logic        m_axis_tlast    // last
);
  import slt_pkg::*;

  logic      in_valid;
  logic [7:0] in_char;
  logic      in_eol;
  logic      room;
  logic      fire;
  step_out_t step;
  result_t   head;

  assign fire = in_valid && room;

  slt_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (fire),
    .valid_o       (in_valid),
    .char_o        (in_char),
    .eol_o         (in_eol)
  );

  slt_scanner #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (in_char),
    .eol_i  (in_eol),
    .step_o (step)
  );

  slt_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .step_i  (step),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {6'b0, head.end_column, head.start_column, head.line_index, head.kind};
  assign m_axis_tlast = head.last;

endmodule

### tb/testbench.sv
// testbench for source_line_tokenizer: streams source text in and checks every token span
// expected spans come from a scanner written here; depends on slt_pkg and the tokenizer rtl
module testbench;
  import slt_pkg::*;

  localparam int unsigned COL_BITS = 12;
  localparam logic [COL_BITS-1:0] COL_LIMIT = {COL_BITS{1'b1}};
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    kind_e       kind;
    logic [31:0] line;
    logic [11:0] first_col;
    logic [11:0] end_col;
    logic        last;
  } span_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic        s_axis_tuser;   // [0] end_of_line
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [1:0] kind, [33:2] line, [45:34] start, [57:46] end, zero
  logic        m_axis_tlast;   // last

  // scanner state mirrored from the block
  mode_e               scan_mode;
  logic [COL_BITS-1:0] tok_start;
  logic [COL_BITS-1:0] col_count;
  logic [31:0]         line_no;
  bit                  all_dig;
  bit                  lead_minus;
  bit                  dig_seen;

  span_t       item_spans[$];
  span_t       pending_spans[$];
  logic [7:0]  line_buf[$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned kind_hits[4];
  int unsigned idle_cycles;
  bit          steady;
  bit          hold_armed;

  source_line_tokenizer #(.COLUMN_BITS(COL_BITS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit byte_is_blank(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic bit byte_is_bracket(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit byte_is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  function automatic void push_span(input kind_e k, input logic [COL_BITS-1:0] s,
                                    input logic [COL_BITS-1:0] e);
    span_t sp;
    sp.kind      = k;
    sp.line      = line_no;
    sp.first_col = s[11:0];
    sp.end_col   = e[11:0];
    sp.last      = 1'b0;
    item_spans   = {item_spans, sp};
  endfunction

  function automatic void emit_word(input logic [COL_BITS-1:0] e);
    push_span((all_dig && dig_seen) ? KIND_INT : KIND_WORD, tok_start, e);
  endfunction

  function automatic void open_token(input logic [7:0] c, input logic [COL_BITS-1:0] pos,
                                     input logic [COL_BITS-1:0] nxt);
    if (byte_is_blank(c)) begin
      scan_mode = MODE_IDLE;
    end else if (c == CH_HASH) begin
      scan_mode = MODE_COMMENT;
    end else if (c == CH_QUOTE) begin
      scan_mode = MODE_STRING;
      tok_start = pos;
    end else if (byte_is_bracket(c)) begin
      scan_mode = MODE_IDLE;
      push_span(KIND_WORD, pos, nxt);
    end else begin
      scan_mode  = MODE_WORD;
      tok_start  = pos;
      lead_minus = (c == CH_MINUS);
      dig_seen   = byte_is_digit(c);
      all_dig    = lead_minus || dig_seen;
    end
  endfunction

  // advance the scanner by one accepted item and queue the spans it yields
  function automatic void scan_item(input logic [7:0] ch, input logic eol);
    logic [COL_BITS-1:0] pos;
    logic [COL_BITS-1:0] nxt;
    if (eol) begin
      if (scan_mode == MODE_WORD) begin
        emit_word(col_count);
      end else if (scan_mode == MODE_STRING || scan_mode == MODE_ESCAPE) begin
        push_span(KIND_ERROR, tok_start, col_count);
      end
      if (line_no != 32'hFFFF_FFFF) line_no++;
      col_count = '0;
      scan_mode = MODE_IDLE;
    end else begin
      pos = col_count;
      nxt = (pos == COL_LIMIT) ? pos : pos + 1'b1;
      case (scan_mode)
        MODE_COMMENT: ;
        MODE_STRING: begin
          if (ch == CH_BSLASH) begin
            scan_mode = MODE_ESCAPE;
          end else if (ch == CH_QUOTE) begin
            push_span(KIND_STRING, tok_start, nxt);
            scan_mode = MODE_IDLE;
          end
        end
        MODE_ESCAPE: scan_mode = MODE_STRING;
        MODE_WORD: begin
          if (byte_is_blank(ch) || ch == CH_HASH || byte_is_bracket(ch)) begin
            emit_word(pos);
            open_token(ch, pos, nxt);
          end else if (byte_is_digit(ch)) begin
            dig_seen = 1'b1;
          end else begin
            all_dig = 1'b0;
          end
        end
        default: open_token(ch, pos, nxt);
      endcase
      col_count = nxt;
    end
    if (item_spans.size() > 0) item_spans[item_spans.size()-1].last = 1'b1;
    pending_spans = {pending_spans, item_spans};
    item_spans.delete();
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("mismatch in %s of result %0d: got 0x%0h, expected 0x%0h",
             field, results_seen, got_v, want_v);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    span_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        want = pending_spans.pop_front();
        kind_hits[want.kind]++;
        if (m_axis_tdata[1:0] !== want.kind)
          report_mismatch("token_kind", 64'(m_axis_tdata[1:0]), 64'(want.kind));
        if (m_axis_tdata[33:2] !== want.line)
          report_mismatch("line_index", 64'(m_axis_tdata[33:2]), 64'(want.line));
        if (m_axis_tdata[45:34] !== want.first_col)
          report_mismatch("start_column", 64'(m_axis_tdata[45:34]), 64'(want.first_col));
        if (m_axis_tdata[57:46] !== want.end_col)
          report_mismatch("end_column", 64'(m_axis_tdata[57:46]), 64'(want.end_col));
        if (m_axis_tdata[63:58] !== 6'd0)
          report_mismatch("tdata padding", 64'(m_axis_tdata[63:58]), 64'd0);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
      end
      results_seen++;
    end
  end

  // ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results still due",
                 IDLE_LIMIT, pending_spans.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side ready, with random stalls and an optional long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_item(ch, eol);
    items_sent++;
    // idle cycles between items, about 29 of a hundred
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_line();
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 5))
      0: return CH_ZERO + 8'($urandom_range(0, 9));
      1: return CH_MINUS;
      2: return CH_QUOTE;
      3: return 8'($urandom_range(128, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // appends one token and maybe a blank; returns 1 when the rest of the line is swallowed
  function automatic bit append_token(input bit open_ok);
    int unsigned pick;
    logic [7:0] b;
    bit ends_line;
    ends_line = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 6)) add_byte(word_byte());
    end else if (pick < 45) begin
      if ($urandom_range(0, 1)) add_byte(CH_MINUS);
      repeat ($urandom_range(1, 5)) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) add_byte(CH_MINUS);
    end else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0: add_byte(CH_LPAREN);
        1: add_byte(CH_RPAREN);
        2: add_byte(CH_LBRACK);
        default: add_byte(CH_RBRACK);
      endcase
    end else if (pick < 72) begin
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          add_byte(CH_BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          b = 8'($urandom_range(0, 255));
          add_byte((b == CH_QUOTE || b == CH_BSLASH) ? CH_SPACE : b);
        end
      end
      if (!open_ok || $urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      else ends_line = 1'b1;
    end else if (pick < 78 && open_ok) begin
      add_byte(CH_HASH);
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
      ends_line = 1'b1;
    end else begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        if (!open_ok && (b == CH_QUOTE || b == CH_HASH)) b = CH_MINUS;
        add_byte(b);
      end
    end
    if (!ends_line && $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 5);
      add_byte(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
    end
    return ends_line;
  endfunction

  task automatic test_directed_cases();
    send_text("-7(x#q");             // integer closed by bracket, word closed by comment
    send_text("- \"\\\"]");          // lone minus, escaped quote, unterminated string
    send_text("a\"\t\"\\");          // quote inside word, backslash at line end
    send_text("");                   // empty line
    send_text("--1\377");            // double minus and high byte, word closed by line end
  endtask

  task automatic test_random_text(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, 8)) begin
        if (append_token(1'b1)) break;
      end
      send_line();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    test_random_text(300);
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_armed = 1'b1;
    // every bracket yields a span, two when it closes a word
    repeat (40) send_text("ab(]-5[)");
    steady = 1'b0;
    wait_all_results();
  endtask

  initial begin
    scan_mode     = MODE_IDLE;
    tok_start     = '0;
    col_count     = '0;
    line_no       = 32'd1;
    all_dig       = 1'b1;
    lead_minus    = 1'b0;
    dig_seen      = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    idle_cycles   = 0;
    steady        = 1'b0;
    hold_armed    = 1'b0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tuser  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_text(1000);
    test_steady_stream();
    test_output_backpressure();
    test_random_text(200);

    wait_all_results();
    repeat (16) @(posedge clk_i);
    $display("ran %0d items over %0d lines into %0d spans: %0d word/bracket, %0d integer,",
             items_sent, line_no - 1, results_seen, kind_hits[KIND_WORD], kind_hits[KIND_INT]);
    $display("  %0d string, %0d unterminated; with a long output hold-off and a gapless stretch",
             kind_hits[KIND_STRING], kind_hits[KIND_ERROR]);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### source_line_tokenizer.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_in_reg.sv
hw/rtl/slt_scanner.sv
hw/rtl/slt_out_fifo.sv
hw/rtl/source_line_tokenizer.sv
tb/testbench.sv
